// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the hash table RTL.
// Depends on nothing; included by files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ===== rtl/lpht_pkg.sv =====
// Package for the linear probe hash table: payload types, codes, hash constants.
// Depends on nothing.
`default_nettype none
package lpht_pkg;
    typedef enum logic [1:0] {MODE_LOOKUP = 2'd0, MODE_INSERT = 2'd1, MODE_DELETE = 2'd2,
                              MODE_NONE = 2'd3} mode_t;
    typedef enum logic [1:0] {ST_OK = 2'd0, ST_MISSING = 2'd1, ST_FULL = 2'd2,
                              ST_RSVD = 2'd3} status_t;
    localparam logic [1:0] MARK_EMPTY   = 2'd0;
    localparam logic [1:0] MARK_USED    = 2'd1;
    localparam logic [1:0] MARK_DELETED = 2'd2;

    localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] MUL1   = 64'hbf58476d1ce4e5b9;
    localparam logic [63:0] MUL2   = 64'h94d049bb133111eb;

    typedef struct packed {
        logic [1:0]         mode;
        logic [63:0]        lookup_key;
        logic signed [31:0] write_value;
    } req_t;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
    } rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE, BK_CLEAR, BK_ISSUE, BK_WAIT, BK_CHECK, BK_DONE
    } bk_state_t;

    typedef enum logic [2:0] {
        HS_IDLE, HS_ADD, HS_M1, HS_M2, HS_OUT
    } hs_state_t;
endpackage
`default_nettype wire

// ===== rtl/linear_probe_hash_table.sv =====
// Linear probing hash table, a front hash stage feeding a probe back end.
// The front end hashes and queues each request; the back end probes slot by slot
// and then registers the response at the output.
// The hash sequencer takes a new request only once the last one is queued; the back
// end serves one request at a time, and each extra probed slot slows it down.
// Reset: asynchronous, active low; a clearing pass over every slot empties
// the slot marks, during which requests queue but are not served.
`default_nettype none
module linear_probe_hash_table #(
    parameter int CAPACITY = 1024
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire lpht_pkg::req_t req,
    output logic                empty,
    input  wire logic           pop,
    output lpht_pkg::rsp_t      rsp
);
    localparam int IDXW = $clog2(CAPACITY);

    logic            q_valid, q_take;
    lpht_pkg::req_t  q_req;
    logic [IDXW-1:0] q_home;

    lpht_front #(.IDXW(IDXW)) u_front (
        .clk(clk), .rst_n(rst_n), .push(push), .full(full), .req(req),
        .q_valid(q_valid), .q_take(q_take), .q_req(q_req), .q_home(q_home)
    );

    lpht_back #(.IDXW(IDXW), .CAPACITY(CAPACITY)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_take(q_take),
        .q_req(q_req), .q_home(q_home), .empty(empty), .pop(pop), .rsp(rsp)
    );
endmodule
`default_nettype wire

// ===== rtl/lpht_ram.sv =====
// Generic RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/lpht_mul64.sv =====
// 64x64 low-half multiplier, three 32x32 partial products over cycles.
// Depends on nothing.
`default_nettype none
module lpht_mul64 (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] a,
    input  wire logic [63:0] b,
    output logic             done,
    output logic [63:0]      p
);
    logic [1:0]  step_reg;
    logic        busy_reg;
    logic [63:0] a_reg, b_reg, acc_reg;
    logic [31:0] op_a, op_b;
    logic [63:0] prod;

    // pick the partial product for this step: lo*lo, lo*hi, hi*lo
    always_comb
    begin
        case (step_reg)
            2'd0:    begin op_a = a_reg[31:0];  op_b = b_reg[31:0];  end
            2'd1:    begin op_a = a_reg[31:0];  op_b = b_reg[63:32]; end
            default: begin op_a = a_reg[63:32]; op_b = b_reg[31:0];  end
        endcase
        prod = 64'(op_a) * 64'(op_b);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= 2'd0;
            done     <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                if (step_reg == 2'd2)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
                step_reg <= step_reg + 2'd1;
            end
        end
    end

    // accumulate; cross terms land in the upper half only
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg == 2'd0)
            begin
                acc_reg <= prod;
            end
            else
            begin
                acc_reg <= acc_reg + {prod[31:0], 32'd0};
            end
        end
    end

    assign p = acc_reg;
endmodule
`default_nettype wire

// ===== rtl/lpht_front.sv =====
// Front end: accepts requests, hashes the key, queues hashed requests.
// Depends on lpht_pkg, lpht_mul64 and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lpht_front #(
    parameter int IDXW = 10
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    output logic                full,
    input  wire lpht_pkg::req_t req,
    output logic                q_valid,
    input  wire logic           q_take,
    output lpht_pkg::req_t      q_req,
    output logic [IDXW-1:0]     q_home
);
    lpht_pkg::hs_state_t state_reg, state_next;
    lpht_pkg::req_t      cur_reg;
    logic [63:0]         v_reg, v_next;
    logic                mul_start, mul_done;
    logic [63:0]         mul_a, mul_b, mul_p;
    // two-entry queue toward the back end
    lpht_pkg::req_t  qr_reg [2];
    logic [IDXW-1:0] qh_reg [2];
    logic [1:0]      cnt_reg;
    logic            rd_reg, wr_reg;
    logic            enq;

    lpht_mul64 u_mul (
        .clk(clk), .rst_n(rst_n), .start(mul_start), .a(mul_a), .b(mul_b),
        .done(mul_done), .p(mul_p)
    );

    assign full = (state_reg != lpht_pkg::HS_IDLE);

    // hash sequencer: add, mix-multiply twice, final xor-shift
    always_comb
    begin
        state_next = state_reg;
        v_next     = v_reg;
        mul_start  = 1'b0;
        mul_a      = v_reg ^ (v_reg >> 30);
        mul_b      = lpht_pkg::MUL1;
        enq        = 1'b0;
        unique case (state_reg)
            lpht_pkg::HS_IDLE:
            begin
                if (push)
                begin
                    v_next     = req.lookup_key + lpht_pkg::GOLDEN;
                    state_next = lpht_pkg::HS_ADD;
                end
            end
            lpht_pkg::HS_ADD:
            begin
                mul_start  = 1'b1;
                state_next = lpht_pkg::HS_M1;
            end
            lpht_pkg::HS_M1:
            begin
                if (mul_done)
                begin
                    v_next     = mul_p;
                    state_next = lpht_pkg::HS_M2;
                    mul_start  = 1'b1;
                    mul_a      = mul_p ^ (mul_p >> 27);
                    mul_b      = lpht_pkg::MUL2;
                end
            end
            lpht_pkg::HS_M2:
            begin
                mul_a = v_reg ^ (v_reg >> 27);
                mul_b = lpht_pkg::MUL2;
                if (mul_done)
                begin
                    v_next     = mul_p ^ (mul_p >> 31);
                    state_next = lpht_pkg::HS_OUT;
                end
            end
            lpht_pkg::HS_OUT:
            begin
                if (cnt_reg != 2'd2)
                begin
                    enq        = 1'b1;
                    state_next = lpht_pkg::HS_IDLE;
                end
            end
            default: state_next = lpht_pkg::HS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lpht_pkg::HS_IDLE;
            cnt_reg   <= 2'd0;
            rd_reg    <= 1'b0;
            wr_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (enq)
            begin
                wr_reg <= ~wr_reg;
            end
            if (q_take && q_valid)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, enq} - {1'b0, q_take && q_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        if (state_reg == lpht_pkg::HS_IDLE && push)
        begin
            cur_reg <= req;
        end
        if (enq)
        begin
            qr_reg[wr_reg] <= cur_reg;
            qh_reg[wr_reg] <= v_reg[IDXW-1:0];
        end
    end

    assign q_valid = (cnt_reg != 2'd0);
    assign q_req   = qr_reg[rd_reg];
    assign q_home  = qh_reg[rd_reg];

    `ASSERT_IMPL(a_q_bound, clk, rst_n, 1'b1, cnt_reg <= 2'd2)
    `ASSERT_IMPL(a_no_enq_full, clk, rst_n, enq, cnt_reg != 2'd2)
endmodule
`default_nettype wire

// ===== rtl/lpht_back.sv =====
// Back end: probes the slot memories and produces one response per request.
// Depends on lpht_pkg, lpht_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module lpht_back #(
    parameter int IDXW = 10,
    parameter int CAPACITY = 1024
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    output logic                 q_take,
    input  wire lpht_pkg::req_t  q_req,
    input  wire logic [IDXW-1:0] q_home,
    output logic                 empty,
    input  wire logic            pop,
    output lpht_pkg::rsp_t       rsp
);
    localparam int CNTW = IDXW + 1;
    localparam logic [CNTW+3:0] LIMIT = (CNTW+4)'((CAPACITY * 7 + 9) / 10);

    lpht_pkg::bk_state_t state_reg, state_next;
    lpht_pkg::req_t  req_reg;
    logic [IDXW-1:0] pos_reg, pos_next, free_reg, free_next;
    logic            have_free_reg, have_free_next;
    logic [CNTW-1:0] n_reg, n_next, used_reg, used_next;
    logic [IDXW-1:0] clr_reg;
    logic            out_valid_reg, out_valid_next;
    lpht_pkg::rsp_t  out_reg, out_next;
    // result of the current request, held until the output register frees up
    lpht_pkg::rsp_t  res_reg, res_next;

    logic            mk_we, kv_we;
    logic [IDXW-1:0] mk_waddr, kv_waddr;
    logic [1:0]      mk_wdata, mk_rdata;
    logic [95:0]     kv_wdata, kv_rdata;
    logic            load_ok;

    lpht_ram #(.WIDTH(2), .DEPTH(CAPACITY)) u_marks (
        .clk(clk), .we(mk_we), .waddr(mk_waddr), .wdata(mk_wdata),
        .raddr(pos_reg), .rdata(mk_rdata)
    );
    lpht_ram #(.WIDTH(96), .DEPTH(CAPACITY)) u_kv (
        .clk(clk), .we(kv_we), .waddr(kv_waddr), .wdata(kv_wdata),
        .raddr(pos_reg), .rdata(kv_rdata)
    );

    // (used+1)*10 >= CAPACITY*7 is the same as used+1 >= ceil(CAPACITY*7/10)
    assign load_ok = ((CNTW+4)'(used_reg) + (CNTW+4)'(1)) < LIMIT;

    assign empty = !out_valid_reg;
    assign rsp   = out_reg;

    // probe sequencer: issue read, wait state, check the slot
    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        free_next      = free_reg;
        have_free_next = have_free_reg;
        n_next         = n_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        res_next       = res_reg;
        q_take         = 1'b0;
        mk_we          = 1'b0;
        mk_waddr       = pos_reg;
        mk_wdata       = lpht_pkg::MARK_USED;
        kv_we          = 1'b0;
        kv_waddr       = pos_reg;
        kv_wdata       = {req_reg.lookup_key, req_reg.write_value};
        unique case (state_reg)
            lpht_pkg::BK_CLEAR:
            begin
                mk_we    = 1'b1;
                mk_waddr = clr_reg;
                mk_wdata = lpht_pkg::MARK_EMPTY;
                if (clr_reg == IDXW'(CAPACITY - 1))
                begin
                    state_next = lpht_pkg::BK_IDLE;
                end
            end
            lpht_pkg::BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_take         = 1'b1;
                    pos_next       = q_home;
                    n_next         = '0;
                    have_free_next = 1'b0;
                    state_next     = lpht_pkg::BK_ISSUE;
                end
            end
            lpht_pkg::BK_ISSUE: state_next = lpht_pkg::BK_WAIT;
            lpht_pkg::BK_WAIT:  state_next = lpht_pkg::BK_CHECK;
            lpht_pkg::BK_CHECK:
            begin
                res_next.status     = lpht_pkg::ST_MISSING;
                res_next.read_value = '0;
                state_next          = lpht_pkg::BK_DONE;
                if (req_reg.mode == lpht_pkg::MODE_NONE)
                begin
                    // unused mode: report not found, touch nothing
                end
                else if (mk_rdata == lpht_pkg::MARK_USED &&
                         kv_rdata[95:32] == req_reg.lookup_key)
                begin
                    res_next.status = lpht_pkg::ST_OK;
                    if (req_reg.mode == lpht_pkg::MODE_LOOKUP)
                    begin
                        res_next.read_value = kv_rdata[31:0];
                    end
                    else if (req_reg.mode == lpht_pkg::MODE_INSERT)
                    begin
                        kv_we = 1'b1;
                    end
                    else
                    begin
                        mk_we     = 1'b1;
                        mk_wdata  = lpht_pkg::MARK_DELETED;
                        used_next = (used_reg != '0) ? used_reg - CNTW'(1) : used_reg;
                    end
                end
                else if (mk_rdata == lpht_pkg::MARK_EMPTY ||
                         n_reg == CNTW'(CAPACITY - 1))
                begin
                    // probe ends here
                    if (req_reg.mode == lpht_pkg::MODE_INSERT)
                    begin
                        if (!load_ok)
                        begin
                            res_next.status = lpht_pkg::ST_FULL;
                        end
                        else if (have_free_reg)
                        begin
                            res_next.status = lpht_pkg::ST_OK;
                            mk_we = 1'b1; kv_we = 1'b1;
                            mk_waddr = free_reg; kv_waddr = free_reg;
                            used_next = used_reg + CNTW'(1);
                        end
                        else if (mk_rdata != lpht_pkg::MARK_USED)
                        begin
                            res_next.status = lpht_pkg::ST_OK;
                            mk_we = 1'b1; kv_we = 1'b1;
                            used_next = used_reg + CNTW'(1);
                        end
                        else
                        begin
                            res_next.status = lpht_pkg::ST_FULL;
                        end
                    end
                end
                else
                begin
                    // keep probing; note first tombstone
                    if (mk_rdata != lpht_pkg::MARK_USED && !have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_next      = pos_reg;
                    end
                    pos_next   = pos_reg + IDXW'(1);
                    n_next     = n_reg + CNTW'(1);
                    state_next = lpht_pkg::BK_ISSUE;
                end
            end
            lpht_pkg::BK_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    state_next     = lpht_pkg::BK_IDLE;
                end
            end
            default: state_next = lpht_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lpht_pkg::BK_CLEAR;
            clr_reg       <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            have_free_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_reg + IDXW'(1);
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            have_free_reg <= have_free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        free_reg <= free_next;
        n_reg    <= n_next;
        out_reg  <= out_next;
        res_reg  <= res_next;
        if (q_take)
        begin
            req_reg <= q_req;
        end
    end

    `ASSERT_IMPL(a_used_bound, clk, rst_n, 1'b1, used_reg < CNTW'(CAPACITY))
    `ASSERT_NEXT(a_take_idle, clk, rst_n, q_take, state_reg == lpht_pkg::BK_ISSUE)
endmodule
`default_nettype wire

// ===== tb/sv/linear_probe_hash_table_tb.sv =====
// Testbench for linear_probe_hash_table: directed, fill and random request beats,
// checked against an in-bench open-addressing map model. Depends on lpht_pkg and the RTL.
`timescale 1ns / 100ps
`default_nettype none

// Keeps a shadow copy of the table and the queue of responses still owed by the block.
class hash_scoreboard;
    localparam int SLOTS = 1024;
    logic [1:0]         marks [SLOTS];
    logic [63:0]        keys  [SLOTS];
    logic signed [31:0] vals  [SLOTS];
    int unsigned        used_cnt;
    lpht_pkg::rsp_t     owed [$];
    int                 errors;

    function new();
        for (int i = 0; i < SLOTS; i++)
        begin
            marks[i] = lpht_pkg::MARK_EMPTY;
            keys[i]  = '0;
            vals[i]  = '0;
        end
        used_cnt = 0;
        errors   = 0;
    endfunction

    // splitmix64 finalizer, low bits pick the home slot
    function int unsigned home_of(logic [63:0] k);
        logic [63:0] v;
        v = k + lpht_pkg::GOLDEN;
        v = (v ^ (v >> 30)) * lpht_pkg::MUL1;
        v = (v ^ (v >> 27)) * lpht_pkg::MUL2;
        v = v ^ (v >> 31);
        return int'(v[9:0]);
    endfunction

    // returns slot of a live entry holding k, or -1
    function int locate(logic [63:0] k);
        int unsigned p;
        p = home_of(k);
        for (int n = 0; n < SLOTS; n++)
        begin
            if (marks[p] == lpht_pkg::MARK_EMPTY)
                return -1;
            if (marks[p] == lpht_pkg::MARK_USED && keys[p] == k)
                return int'(p);
            p = (p + 1) % SLOTS;
        end
        return -1;
    endfunction

    function lpht_pkg::status_t store(logic [63:0] k, logic signed [31:0] v);
        int unsigned p;
        int unsigned spot;
        bit          have_spot;
        p = home_of(k);
        have_spot = 0;
        spot = 0;
        for (int n = 0; n < SLOTS; n++)
        begin
            if (marks[p] == lpht_pkg::MARK_EMPTY)
            begin
                if (!have_spot)
                begin
                    have_spot = 1;
                    spot = p;
                end
                break;
            end
            if (marks[p] == lpht_pkg::MARK_USED)
            begin
                if (keys[p] == k)
                begin
                    vals[p] = v;
                    return lpht_pkg::ST_OK;
                end
            end
            else if (!have_spot)
            begin
                // first tombstone on the path gets reused
                have_spot = 1;
                spot = p;
            end
            p = (p + 1) % SLOTS;
        end
        if ((used_cnt + 1) * 10 >= SLOTS * 7)
            return lpht_pkg::ST_FULL;
        if (!have_spot)
            return lpht_pkg::ST_FULL;
        marks[spot] = lpht_pkg::MARK_USED;
        keys[spot]  = k;
        vals[spot]  = v;
        used_cnt++;
        return lpht_pkg::ST_OK;
    endfunction

    // accepted request beat: update the shadow table, queue the owed response
    function void note_request(lpht_pkg::req_t r);
        lpht_pkg::rsp_t e;
        int at;
        e.status = lpht_pkg::ST_MISSING;
        e.read_value = '0;
        case (lpht_pkg::mode_t'(r.mode))
            lpht_pkg::MODE_LOOKUP:
            begin
                at = locate(r.lookup_key);
                if (at >= 0)
                begin
                    e.status = lpht_pkg::ST_OK;
                    e.read_value = vals[at];
                end
            end
            lpht_pkg::MODE_INSERT:
                e.status = store(r.lookup_key, r.write_value);
            lpht_pkg::MODE_DELETE:
            begin
                at = locate(r.lookup_key);
                if (at >= 0)
                begin
                    marks[at] = lpht_pkg::MARK_DELETED;
                    if (used_cnt > 0)
                        used_cnt--;
                    e.status = lpht_pkg::ST_OK;
                end
            end
            default: ;
        endcase
        owed.push_back(e);
    endfunction

    // accepted response beat: compare with the oldest owed one
    function void check_response(lpht_pkg::rsp_t a);
        lpht_pkg::rsp_t e;
        if (owed.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected response: status=%0d read_value=%0d",
                         a.status, a.read_value);
            return;
        end
        e = owed.pop_front();
        if (a.status !== e.status || a.read_value !== e.read_value)
        begin
            errors++;
            if (errors <= 10)
                $display("mismatch: expected status=%0d read_value=%0d, got status=%0d read_value=%0d",
                         e.status, e.read_value, a.status, a.read_value);
        end
    endfunction

    function int pending();
        return owed.size();
    endfunction
endclass

module linear_probe_hash_table_tb;
    localparam int IDLE_LIMIT = 20000;
    localparam int HOLD_CYCLES = 600;

    logic           clk;
    logic           rst_n;
    logic           push;
    logic           full;
    lpht_pkg::req_t req;
    logic           empty;
    logic           pop;
    lpht_pkg::rsp_t rsp;

    hash_scoreboard sb;
    bit             calm;
    bit             hold_now;
    int             idle_cycles;
    logic [63:0]    key_pool [64];
    logic [63:0]    filled [$];

    linear_probe_hash_table u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .req   (req),
        .empty (empty),
        .pop   (pop),
        .rsp   (rsp)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one request beat, with an optional random gap ahead of it
    task automatic send(input lpht_pkg::mode_t m, input logic [63:0] k,
                        input logic signed [31:0] v);
        lpht_pkg::req_t r;
        int gap;
        r.mode = m;
        r.lookup_key = k;
        r.write_value = v;
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        req  <= r;
        do
            @(posedge clk);
        while (full);
        sb.note_request(r);
    endtask

    function automatic logic [63:0] rand_key();
        return {$urandom, $urandom};
    endfunction

    // response side: random stall bursts plus the requested long hold-off
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_response(rsp);
            if (hold_now)
            begin
                hold_now = 0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                pop <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                pop <= 1'b0;
            end
            else
                pop <= 1'b1;
        end
    end

    initial
    begin : stimulus
        int pick;
        lpht_pkg::mode_t m;
        logic [63:0] k;
        sb = new();
        calm = 0;
        hold_now = 0;
        idle_cycles = 0;
        push <= 1'b0;
        req  <= '0;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < 64; i++)
            key_pool[i] = rand_key();

        // directed: extremes, every mode, update, tombstone reuse, unused mode
        send(lpht_pkg::MODE_LOOKUP, 64'h0, 32'sh0);
        send(lpht_pkg::MODE_INSERT, 64'h0, 32'sh7fffffff);
        send(lpht_pkg::MODE_INSERT, '1, 32'sh80000000);
        send(lpht_pkg::MODE_LOOKUP, 64'h0, 32'sh12345678);
        send(lpht_pkg::MODE_LOOKUP, '1, 32'sh0);
        send(lpht_pkg::MODE_INSERT, 64'h0, -32'sd1);
        send(lpht_pkg::MODE_LOOKUP, 64'h0, 32'sh0);
        send(lpht_pkg::MODE_DELETE, 64'h5555aaaa5555aaaa, 32'sh0);
        send(lpht_pkg::MODE_DELETE, 64'h0, 32'sh0);
        send(lpht_pkg::MODE_LOOKUP, 64'h0, 32'sh0);
        send(lpht_pkg::MODE_DELETE, 64'h0, 32'sh0);
        send(lpht_pkg::MODE_INSERT, 64'h0, 32'sh0);
        send(lpht_pkg::MODE_LOOKUP, 64'h0, 32'sh0);
        send(lpht_pkg::MODE_NONE, '1, 32'sh7fffffff);
        send(lpht_pkg::MODE_INSERT, 64'h8000000000000001, 32'sh55aa55aa);
        send(lpht_pkg::MODE_LOOKUP, 64'h8000000000000001, 32'sh0);
        send(lpht_pkg::MODE_NONE, 64'h0, 32'sh0);

        // fill part of the table with fresh keys
        for (int i = 0; i < 100; i++)
        begin
            k = rand_key();
            filled.push_back(k);
            send(lpht_pkg::MODE_INSERT, k, $urandom);
        end
        send(lpht_pkg::MODE_INSERT, filled[0], $urandom);   // update of an existing key
        send(lpht_pkg::MODE_LOOKUP, filled[0], 32'sh0);

        // thin out to leave tombstones on the probe paths
        for (int i = 0; i < filled.size(); i += 2)
            send(lpht_pkg::MODE_DELETE, filled[i], 32'sh0);

        // random mix over a small key pool plus old and fresh keys
        for (int n = 0; n < 481; n++)
        begin
            if (n == 150)
                hold_now = 1;
            if (n == 400)
                calm = 1;
            pick = $urandom_range(0, 99);
            if (pick < 35)
                m = lpht_pkg::MODE_LOOKUP;
            else if (pick < 70)
                m = lpht_pkg::MODE_INSERT;
            else if (pick < 95)
                m = lpht_pkg::MODE_DELETE;
            else
                m = lpht_pkg::MODE_NONE;
            pick = $urandom_range(0, 9);
            if (pick < 6)
                k = key_pool[$urandom_range(0, 63)];
            else if (pick < 8)
                k = filled[$urandom_range(0, filled.size() - 1)];
            else
                k = rand_key();
            send(m, k, $urandom);
        end
        push <= 1'b0;

        // drain, then let the pipeline settle
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (64) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_mul64.sv
rtl/lpht_front.sv
rtl/lpht_back.sv
rtl/linear_probe_hash_table.sv
tb/sv/linear_probe_hash_table_tb.sv
